FILE: rtl/aed_pkg.sv
// Shared types, constants and register codes of the audio envelope decimator.
package aed_pkg;

    localparam int WINDOW_LEN_DEF = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int ENV_W      = 32;
    localparam int DECAY_W    = 32;
    localparam int INTERVAL_W = 12;
    localparam int SLOT_W     = 10;
    localparam int ENERGY_W   = 64;
    localparam int RISE_W     = 24;
    localparam int CFG_W      = 32;

    localparam logic [DECAY_W-1:0]    DECAY_STEP_RST          = 32'd216430;
    localparam logic [INTERVAL_W-1:0] DECIMATION_INTERVAL_RST = 12'd350;

    typedef enum logic [0:0] {
        CFG_DECAY_STEP          = 1'b0,
        CFG_DECIMATION_INTERVAL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic cmp;
        logic square;
        logic finish;
    } dp_cmd_t;

endpackage

FILE: rtl/audio_envelope_decimator_unit.sv
// Top level of the audio envelope decimator: peak envelope, decimation and attack energy.
//
// One signed 16-bit sample enters per input word on the in_valid / in_stall channel,
// with start_of_song clearing envelope, counters and energy sum before that sample.
// Each input word yields exactly one output word on out_valid / out_stall carrying
// the envelope, the decimation flag, window slot, last-slot flag and energy sum.
// An item passes through the steps: accept, then multiply by the decay step, compare
// and update counters, square the rise, and accumulate into the output. The sequencing
// controller handles one word at a time, so a new sample is taken only after the last
// one has finished; the output register lets the next sample enter while the previous
// result still waits. When the receiver stalls, the result holds and the block pauses
// before writing the output register until it is free. Configuration writes through
// cfg_we, cfg_index and cfg_data take effect at the next clock edge; the user must make
// them only while the block is idle, which the block does not enforce. Reset restores
// the default decay step and decimation interval and clears all song state.
module audio_envelope_decimator_unit
    import aed_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       start_of_song,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ENV_W-1:0]           envelope,
    output logic                       decimated_valid,
    output logic [SLOT_W-1:0]          window_slot,
    output logic                       window_complete,
    output logic [ENERGY_W-1:0]        attack_energy,
    input  logic                       cfg_we,
    input  cfg_index_t                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    dp_cmd_t cmd;

    aed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    aed_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .start_of_song   (start_of_song),
        .envelope        (envelope),
        .decimated_valid (decimated_valid),
        .window_slot     (window_slot),
        .window_complete (window_complete),
        .attack_energy   (attack_energy)
    );

endmodule

FILE: rtl/aed_ctrl.sv
// Controller state machine that sequences one word through the datapath.
module aed_ctrl
    import aed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MULT = 5'b00010,
        S_CMP  = 5'b00100,
        S_SQ   = 5'b01000,
        S_ACC  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_finish;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign can_finish = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (can_finish)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/aed_datapath.sv
// Datapath with envelope, decimation counters, energy sum and output registers.
module aed_datapath
    import aed_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic                       cfg_we,
    input  cfg_index_t                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       start_of_song,
    output logic [ENV_W-1:0]           envelope,
    output logic                       decimated_valid,
    output logic [SLOT_W-1:0]          window_slot,
    output logic                       window_complete,
    output logic [ENERGY_W-1:0]        attack_energy
);

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam int EXT_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WINDOW_LEN - 1);

    logic [DECAY_W-1:0]    decay_step_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [ENV_W-1:0]           env_reg;
    logic [INTERVAL_W-1:0]      phase_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       seen_reg;
    logic [ENERGY_W-1:0]        energy_reg;

    logic [2*ENV_W-1:0]  prod_reg;
    logic [RISE_W-1:0]   rise_reg;
    logic [2*RISE_W-1:0] sq_reg;
    logic                emit_reg;
    logic [CNT_W-1:0]    slot_reg;

    logic [ENV_W-1:0]      env_out_reg;
    logic                  dec_out_reg;
    logic [CNT_W-1:0]      slot_out_reg;
    logic                  complete_out_reg;
    logic [ENERGY_W-1:0]   energy_out_reg;

    logic [SAMPLE_W:0]     sext;
    logic [SAMPLE_W:0]     mag;
    logic [ENV_W-1:0]      cand;
    logic [ENV_W-1:0]      decayed;
    logic [ENV_W-1:0]      new_env;
    logic [ENV_W-1:0]      diff;
    logic                  emit;
    logic [INTERVAL_W-1:0] phase_inc;
    logic [ENERGY_W:0]     sum;
    logic [EXT_W-1:0]      slot_ext;

    assign sext      = {sample_reg[SAMPLE_W-1], sample_reg};
    assign mag       = sample_reg[SAMPLE_W-1] ? (~sext + 1'b1) : sext;
    assign cand      = {mag[SAMPLE_W-1:0], {(ENV_W-SAMPLE_W){1'b0}}};
    assign decayed   = env_reg - prod_reg[2*ENV_W-1:ENV_W];
    assign new_env   = (decayed > cand) ? decayed : cand;
    assign diff      = (new_env > env_reg) ? (new_env - env_reg) : '0;
    assign emit      = (phase_reg == '0) && seen_reg;
    assign phase_inc = phase_reg + 1'b1;
    assign sum       = {1'b0, energy_reg} + {{(ENERGY_W-2*RISE_W+1){1'b0}}, sq_reg};
    assign slot_ext  = EXT_W'(slot_out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_step_reg <= DECAY_STEP_RST;
            interval_reg   <= DECIMATION_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DECAY_STEP:          decay_step_reg <= cfg_data[DECAY_W-1:0];
                CFG_DECIMATION_INTERVAL: interval_reg   <= cfg_data[INTERVAL_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg    <= '0;
            phase_reg  <= '0;
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            energy_reg <= '0;
        end
        else
        begin
            if (cmd.load && start_of_song)
            begin
                env_reg    <= '0;
                phase_reg  <= '0;
                count_reg  <= '0;
                seen_reg   <= 1'b0;
                energy_reg <= '0;
            end
            if (cmd.cmp)
            begin
                env_reg  <= new_env;
                seen_reg <= 1'b1;
                if (phase_inc >= interval_reg)
                begin
                    phase_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_inc;
                end
                if (emit)
                begin
                    count_reg <= (count_reg == LAST_SLOT) ? '0 : count_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                energy_reg <= sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.mult)
        begin
            prod_reg <= env_reg * decay_step_reg;
        end
        if (cmd.cmp)
        begin
            rise_reg <= diff[ENV_W-1:ENV_W-RISE_W];
            emit_reg <= emit;
            slot_reg <= emit ? count_reg : '0;
        end
        if (cmd.square)
        begin
            sq_reg <= rise_reg * rise_reg;
        end
        if (cmd.finish)
        begin
            env_out_reg      <= env_reg;
            dec_out_reg      <= emit_reg;
            slot_out_reg     <= slot_reg;
            complete_out_reg <= emit_reg && (slot_reg == LAST_SLOT);
            energy_out_reg   <= sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
        end
    end

    assign envelope        = env_out_reg;
    assign decimated_valid = dec_out_reg;
    assign window_slot     = slot_ext[SLOT_W-1:0];
    assign window_complete = complete_out_reg;
    assign attack_energy   = energy_out_reg;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the audio envelope decimator with a built-in envelope predictor.
`timescale 1ns / 1ps

module testbench
    import aed_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start_of_song;
    } audio_word_t;

    typedef struct packed {
        logic [ENV_W-1:0]    envelope;
        logic                decimated_valid;
        logic [SLOT_W-1:0]   window_slot;
        logic                window_complete;
        logic [ENERGY_W-1:0] attack_energy;
    } envelope_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       start_of_song = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [ENV_W-1:0]           envelope;
    logic                       decimated_valid;
    logic [SLOT_W-1:0]          window_slot;
    logic                       window_complete;
    logic [ENERGY_W-1:0]        attack_energy;
    logic                       cfg_we = 1'b0;
    cfg_index_t                 cfg_index = CFG_DECAY_STEP;
    logic [CFG_W-1:0]           cfg_data = '0;

    audio_word_t    samples_to_send[$];
    envelope_word_t envelope_words_due[$];
    audio_word_t    next_word;
    envelope_word_t due_word;
    logic           word_taken = 1'b0;
    int unsigned    words_queued = 0;
    int unsigned    words_checked = 0;
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    sender_idle_pct = 0;
    int unsigned    receiver_stall_pct = 0;

    logic [DECAY_W-1:0]    decay_reg = DECAY_STEP_RST;
    logic [INTERVAL_W-1:0] interval_reg = DECIMATION_INTERVAL_RST;
    logic [ENV_W-1:0]      env_level = '0;
    logic [INTERVAL_W-1:0] phase = '0;
    int unsigned           slot_count = 0;
    logic                  song_started = 1'b0;
    logic [ENERGY_W-1:0]   energy_sum = '0;

    audio_envelope_decimator_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .start_of_song   (start_of_song),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .envelope        (envelope),
        .decimated_valid (decimated_valid),
        .window_slot     (window_slot),
        .window_complete (window_complete),
        .attack_energy   (attack_energy),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic envelope_word_t follow_envelope(audio_word_t word);
        logic [SAMPLE_W-1:0]   magnitude;
        logic [ENV_W-1:0]      prev_env;
        logic [ENV_W-1:0]      decayed;
        logic [ENV_W-1:0]      next_env;
        logic [63:0]           product;
        logic [RISE_W-1:0]     rise;
        logic [ENERGY_W-1:0]   rise_sq;
        envelope_word_t        result;
        result = '0;
        if (word.start_of_song)
        begin
            env_level = '0;
            phase = '0;
            slot_count = 0;
            song_started = 1'b0;
            energy_sum = '0;
        end
        magnitude = word.sample[SAMPLE_W-1] ? -word.sample : word.sample;
        prev_env = env_level;
        product = {32'b0, prev_env} * {32'b0, decay_reg};
        decayed = prev_env - product[63:32];
        next_env = {magnitude, 16'h0000};
        if (decayed > next_env)
        begin
            next_env = decayed;
        end
        if (phase == 0 && song_started)
        begin
            result.decimated_valid = 1'b1;
            result.window_slot = slot_count[SLOT_W-1:0];
            result.window_complete = (slot_count == WINDOW_LEN_DEF - 1);
            slot_count = (slot_count + 1) % WINDOW_LEN_DEF;
        end
        song_started = 1'b1;
        phase = phase + 1'b1;
        if (phase >= interval_reg)
        begin
            phase = '0;
        end
        rise = (next_env > prev_env) ? RISE_W'((next_env - prev_env) >> 8) : '0;
        rise_sq = {40'b0, rise} * {40'b0, rise};
        if (energy_sum > ~rise_sq)
        begin
            energy_sum = '1;
        end
        else
        begin
            energy_sum = energy_sum + rise_sq;
        end
        env_level = next_env;
        result.envelope = next_env;
        result.attack_energy = energy_sum;
        return result;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int small_value;
        small_value = int'($urandom_range(0, 511)) - 256;
        unique case ($urandom_range(0, 9))
            5, 6:    return small_value[SAMPLE_W-1:0];
            7:       return 16'h8000;
            8:       return 16'h7FFF;
            9:       return 16'h0000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_word = samples_to_send.pop_front();
                    in_valid <= 1'b1;
                    sample <= next_word.sample;
                    start_of_song <= next_word.start_of_song;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (envelope_words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual envelope %0h",
                             $time, envelope);
                    mismatch_count++;
                end
                else
                begin
                    due_word = envelope_words_due.pop_front();
                    words_checked <= words_checked + 1;
                    check_field("envelope", 64'(due_word.envelope), 64'(envelope));
                    check_field("decimated_valid", 64'(due_word.decimated_valid),
                                64'(decimated_valid));
                    check_field("window_slot", 64'(due_word.window_slot), 64'(window_slot));
                    check_field("window_complete", 64'(due_word.window_complete),
                                64'(window_complete));
                    check_field("attack_energy", due_word.attack_energy, attack_energy);
                end
            end
            if (in_valid && !in_stall)
            begin
                envelope_words_due.push_back(
                    follow_envelope(audio_word_t'{sample, start_of_song}));
            end
        end
    end

    task automatic queue_word(logic [SAMPLE_W-1:0] value, logic song_mark);
        samples_to_send.push_back(audio_word_t'{value, song_mark});
        words_queued++;
    endtask

    task automatic wait_until_drained();
        while (words_checked != words_queued)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(cfg_index_t index, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (index)
            CFG_DECAY_STEP:          decay_reg = value;
            CFG_DECIMATION_INTERVAL: interval_reg = value[INTERVAL_W-1:0];
            default:                 ;
        endcase
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct, bit open_song,
                             bit song_marks);
        @(posedge clk);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            queue_word(random_sample(),
                       (open_song && i == 0) || (song_marks && $urandom_range(0, 149) == 0));
        end
        wait_until_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Edge samples and song marks under the reset register values.
        @(posedge clk);
        queue_word(16'h7FFF, 1'b1);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'h5555, 1'b0);
        queue_word(16'hAAAA, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h8000, 1'b1);
        queue_word(16'h0100, 1'b0);
        queue_word(16'h0000, 1'b1);
        queue_word(16'h0000, 1'b1);
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h8001, 1'b0);
        wait_until_drained();

        run_phase(20, 0, 0, 1'b0, 1'b1);

        // One long song across two settings so that the window slot wraps.
        write_register(CFG_DECAY_STEP, 32'h0000_0000);
        write_register(CFG_DECIMATION_INTERVAL, 32'd1);
        run_phase(516, 83, 0, 1'b1, 1'b0);

        write_register(CFG_DECAY_STEP, 32'hFFFF_FFFF);
        write_register(CFG_DECIMATION_INTERVAL, 32'hFFFF_F000);
        run_phase(512, 0, 83, 1'b0, 1'b0);

        write_register(CFG_DECAY_STEP, $urandom());
        write_register(CFG_DECIMATION_INTERVAL, 32'hFFFF_FFFF);
        run_phase(30, 34, 34, 1'b0, 1'b1);

        write_register(CFG_DECAY_STEP, 32'h0001_0000);
        write_register(CFG_DECIMATION_INTERVAL, $urandom_range(2, 20));
        run_phase(30, 0, 0, 1'b0, 1'b1);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
